@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file mvae_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked property, also checked while reset is asserted
`define ASSERT_CLK_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/mvae_pkg.sv @@
// ----------------------------------------------------------------------------
// mvae_pkg
// Types and constants of the MIDI voice allocator with ADSR envelopes.
// ----------------------------------------------------------------------------
package mvae_pkg;

  // Voice count and derived widths
  localparam int VOICES = 2;
  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Field widths
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int LEVEL_W  = 16;
  localparam int STAGE_W  = 3;
  localparam int BEND_W   = 14;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 8;

  // Stream payload widths
  localparam int IN_FIELDS_W  = STATUS_W + NOTE_W + VEL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = IDX_W + NOTE_W + VEL_W + LEVEL_W + STAGE_W + BEND_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Key map
  localparam int KEYS = 128;

  // Command queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // MIDI message kinds (upper nibble of the status byte)
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_BEND     = 4'hE;
  localparam logic [3:0] MSG_SYSTEM   = 4'hF;

  localparam logic [BEND_W-1:0] BEND_CENTER = BEND_W'(8192);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

  // Configuration reset values
  localparam logic [LEVEL_W-1:0] ATTACK_RST  = 16'd328;
  localparam logic [LEVEL_W-1:0] DECAY_RST   = 16'd3277;
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 16'd26214;
  localparam logic [LEVEL_W-1:0] RELEASE_RST = 16'd164;

  // Envelope stage codes
  typedef enum logic [STAGE_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

  // Command codes passed from front to back
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_BEND     = 2'd3
  } op_t;

  // Classified command; a bend carries its low bits in note, high in vel
  typedef struct packed {
    op_t               op;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_EVENT = 2'd1,
    BK_TICK  = 2'd2
  } bk_state_t;

endpackage

@@ design/mvae_ram.sv @@
// ----------------------------------------------------------------------------
// mvae_ram
// Generic single write port RAM with a registered read port.
// ----------------------------------------------------------------------------
module mvae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/mvae_front.sv @@
// ----------------------------------------------------------------------------
// mvae_front
// Input stage: takes stream transactions and turns them into commands.
// ----------------------------------------------------------------------------
module mvae_front import mvae_pkg::*; (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,  // status_byte, data_one, data_two
  input  logic                  in_tuser,  // req_type
  input  logic                  q_ready,
  output logic                  q_push,
  output cmd_t                  q_data
);

  logic [3:0]        kind;
  logic [NOTE_W-1:0] data_one;
  logic [VEL_W-1:0]  data_two;
  logic              keep;
  op_t               op;

  assign kind     = in_tdata[STATUS_W-1:STATUS_W-4];
  assign data_one = in_tdata[STATUS_W +: NOTE_W];
  assign data_two = in_tdata[STATUS_W+NOTE_W +: VEL_W];

  // Classify: ticks always pass, only note and bend messages survive
  always_comb begin
    keep = 1'b1;
    op   = OP_TICK;
    if (!in_tuser) begin
      unique case (kind)
        MSG_NOTE_OFF: op = OP_NOTE_OFF;
        MSG_NOTE_ON:  op = (data_two == '0) ? OP_NOTE_OFF : OP_NOTE_ON;
        MSG_BEND:     op = OP_BEND;
        MSG_SYSTEM:   keep = 1'b0;
        default:      keep = 1'b0;
      endcase
    end
  end

  // Accept whenever the queue has room; drop ignored messages here
  assign in_tready   = q_ready;
  assign q_push      = in_tvalid & q_ready & keep;
  assign q_data.op   = op;
  assign q_data.note = data_one;
  assign q_data.vel  = data_two;

endmodule

@@ design/mvae_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// mvae_cmd_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module mvae_cmd_fifo import mvae_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic ready,
  input  logic pop,
  output cmd_t head,
  output logic valid
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign valid = (cnt_r != '0);
  assign ready = (cnt_r != QCNT_W'(QDEPTH));

endmodule

@@ design/mvae_back.sv @@
// ----------------------------------------------------------------------------
// mvae_back
// Back end: voice allocation, key map, envelope stepping and result output.
// ----------------------------------------------------------------------------
module mvae_back import mvae_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_wdata,
  input  logic                   q_valid,
  input  cmd_t                   q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  // Configuration registers
  logic [LEVEL_W-1:0] attack_step_r, decay_step_r, sustain_level_r, release_step_r;

  // Voice state
  stage_t             stage_r [VOICES];
  stage_t             stage_nxt [VOICES];
  logic [NOTE_W-1:0]  note_r [VOICES];
  logic [NOTE_W-1:0]  note_nxt [VOICES];
  logic [VEL_W-1:0]   vel_r [VOICES];
  logic [VEL_W-1:0]   vel_nxt [VOICES];
  logic [LEVEL_W-1:0] level_r [VOICES];
  logic [LEVEL_W-1:0] level_nxt [VOICES];
  logic [BEND_W-1:0]  bend_r, bend_nxt;
  logic [KEYS-1:0]    key_vld_r, key_vld_nxt;

  // Sequencer
  bk_state_t          state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [VIDX_W-1:0]  cnt_r, cnt_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_free;

  // Key map RAM
  logic              ram_we;
  logic [VIDX_W-1:0] ram_wdata;
  logic [VIDX_W-1:0] ram_rdata;

  // Allocation scratch
  stage_t            stage_tmp [VOICES];
  logic              found;
  logic [VIDX_W-1:0] free_idx;
  logic              any_match;

  // Envelope step of the selected voice
  stage_t             cur_stage, step_stage;
  logic [LEVEL_W-1:0] cur_level, step_level, before_level;
  logic [LEVEL_W:0]   att_sum;
  logic               is_last;

  mvae_ram #(
    .WIDTH (VIDX_W),
    .DEPTH (KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd_r.note),
    .wdata (ram_wdata),
    .raddr (q_head.note),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_tready;
  assign is_last  = (cnt_r == VIDX_W'(VOICES - 1));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_step_r   <= ATTACK_RST;
      decay_step_r    <= DECAY_RST;
      sustain_level_r <= SUSTAIN_RST;
      release_step_r  <= RELEASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK:  attack_step_r   <= cfg_wdata;
        CFG_DECAY:   decay_step_r    <= cfg_wdata;
        CFG_SUSTAIN: sustain_level_r <= cfg_wdata;
        CFG_RELEASE: release_step_r  <= cfg_wdata;
        default:     attack_step_r   <= attack_step_r;
      endcase
    end
  end

  // Envelope step for the voice under the tick counter
  assign cur_stage    = stage_r[cnt_r];
  assign cur_level    = level_r[cnt_r];
  assign att_sum      = {1'b0, cur_level} + {1'b0, attack_step_r};
  assign before_level = (cur_stage == ST_IDLE) ? '0 : cur_level;

  always_comb begin
    unique case (cur_stage)
      ST_ATTACK: begin
        step_level = att_sum[LEVEL_W] ? '1 : att_sum[LEVEL_W-1:0];
        step_stage = step_level[LEVEL_W-1] ? ST_DECAY : ST_ATTACK;
      end
      ST_DECAY: begin
        step_level = (cur_level > decay_step_r) ? cur_level - decay_step_r : '0;
        step_stage = (step_level <= sustain_level_r) ? ST_SUSTAIN : ST_DECAY;
      end
      ST_SUSTAIN: begin
        step_level = sustain_level_r;
        step_stage = ST_SUSTAIN;
      end
      ST_RELEASE: begin
        step_level = (cur_level > release_step_r) ? cur_level - release_step_r : '0;
        step_stage = (step_level == '0) ? ST_IDLE : ST_RELEASE;
      end
      default: begin
        step_level = '0;
        step_stage = ST_IDLE;
      end
    endcase
  end

  // Release the key's old voice, then find the lowest idle voice
  always_comb begin
    stage_tmp = stage_r;
    if (key_vld_r[cmd_r.note] && (int'(ram_rdata) < VOICES)) begin
      stage_tmp[ram_rdata] = ST_RELEASE;
    end
    found    = 1'b0;
    free_idx = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (stage_tmp[v] == ST_IDLE) begin
        found    = 1'b1;
        free_idx = VIDX_W'(v);
      end
    end
  end

  // Any active voice holding the note
  always_comb begin
    any_match = 1'b0;
    for (int v = 0; v < VOICES; v++) begin
      if (note_r[v] == cmd_r.note && stage_r[v] != ST_IDLE) begin
        any_match = 1'b1;
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_head.op == OP_TICK) ? BK_TICK : BK_EVENT;
        end
      end
      BK_EVENT: state_nxt = BK_IDLE;
      BK_TICK: begin
        if (out_free && is_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates
  always_comb begin
    stage_nxt     = stage_r;
    note_nxt      = note_r;
    vel_nxt       = vel_r;
    level_nxt     = level_r;
    bend_nxt      = bend_r;
    key_vld_nxt   = key_vld_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = free_idx;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      BK_IDLE: begin
        // Take the next command; the key map read is issued alongside
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          cnt_nxt = '0;
        end
      end
      BK_EVENT: begin
        case (cmd_r.op)
          OP_NOTE_ON: begin
            stage_nxt                = stage_tmp;
            key_vld_nxt[cmd_r.note]  = found;
            if (found) begin
              stage_nxt[free_idx] = ST_ATTACK;
              note_nxt[free_idx]  = cmd_r.note;
              vel_nxt[free_idx]   = cmd_r.vel;
              level_nxt[free_idx] = '0;
              ram_we              = 1'b1;
            end
          end
          OP_NOTE_OFF: begin
            for (int v = 0; v < VOICES; v++) begin
              if (note_r[v] == cmd_r.note && stage_r[v] != ST_IDLE) begin
                stage_nxt[v] = ST_RELEASE;
              end
            end
            if (any_match) begin
              key_vld_nxt[cmd_r.note] = 1'b0;
            end
          end
          OP_BEND: bend_nxt = {cmd_r.vel, cmd_r.note};
          default: bend_nxt = bend_r;
        endcase
      end
      BK_TICK: begin
        // Emit one voice per cycle while the output is free, and step its envelope
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_last_nxt     = is_last;
          out_data_nxt     = OUT_TDATA_W'({bend_r, STAGE_W'(step_stage), before_level,
                                           vel_r[cnt_r], note_r[cnt_r], IDX_W'(cnt_r)});
          stage_nxt[cnt_r] = step_stage;
          level_nxt[cnt_r] = step_level;
          cnt_nxt          = cnt_r + 1'b1;
        end
      end
      default: cnt_nxt = '0;
    endcase
  end

  // Control and voice state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      bend_r      <= BEND_CENTER;
      key_vld_r   <= '0;
      for (int v = 0; v < VOICES; v++) begin
        stage_r[v] <= ST_IDLE;
        note_r[v]  <= '0;
        vel_r[v]   <= '0;
        level_r[v] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      bend_r      <= bend_nxt;
      key_vld_r   <= key_vld_nxt;
      stage_r     <= stage_nxt;
      note_r      <= note_nxt;
      vel_r       <= vel_nxt;
      level_r     <= level_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ design/midi_voice_allocator_envelope.sv @@
// ----------------------------------------------------------------------------
// midi_voice_allocator_envelope
// Polyphonic MIDI voice allocator with a linear ADSR envelope per voice.
// ----------------------------------------------------------------------------
// The input accepts one transaction per cycle while the two-entry command
// queue has room; unsupported MIDI messages are dropped on entry. The back
// end handles one command at a time: a note or bend event is a queue pop
// with the key map RAM read, then the update; a sample tick walks the
// voices, one per cycle while the output is free, through the single
// envelope step unit, which emits each result into the output register.
// A stalled result output holds the back end; the queue keeps taking input
// until it fills. Levels are unsigned Q1.15, full scale 32768.
module midi_voice_allocator_envelope import mvae_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // status_byte, data_one, data_two
  input  logic                   in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // voice_index, voice_note, voice_velocity, voice_level, voice_stage, bend_value
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast   // last_voice
);

  logic q_ready, q_push, q_pop, q_valid;
  cmd_t q_data, q_head;

  mvae_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  mvae_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .ready     (q_ready),
    .pop       (q_pop),
    .head      (q_head),
    .valid     (q_valid)
  );

  mvae_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ design/mvae_checker.sv @@
// ----------------------------------------------------------------------------
// mvae_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mvae_checker import mvae_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // No result shows right after reset
  `ASSERT_CLK_NR(a_reset_quiet, !rst_n |=> !out_tvalid, "result valid after reset")

  // A stalled result holds its payload
  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // The last flag marks exactly the highest voice
  `ASSERT_CLK(a_last_voice, out_tvalid |-> (out_tlast == (out_tdata[IDX_W-1:0] == IDX_W'(VOICES - 1))), "last flag does not match voice index")

  // Within a tick voices come out in ascending order
  `ASSERT_CLK(a_voice_order, out_tvalid && out_tready && !out_tlast ##1 out_tvalid |-> out_tdata[IDX_W-1:0] == $past(out_tdata[IDX_W-1:0]) + 1'b1, "voice index out of order")

endmodule

bind midi_voice_allocator_envelope mvae_checker u_mvae_checker (.*);

@@ sim/voice_checker.sv @@
// ----------------------------------------------------------------------------
// voice_checker
// Predicts and checks the per-voice results of the MIDI voice allocator.
// ----------------------------------------------------------------------------
// Watches the input, result and register write ports. Every accepted MIDI
// event updates a local copy of the voice table, key map and bend register.
// Every accepted sample tick queues one expected result per voice. Accepted
// results are compared field by field with the oldest queued result.
module voice_checker import mvae_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [LEVEL_W-1:0]     cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // status_byte, data_one, data_two
  input  logic                   in_tuser,   // req_type
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // voice_index, voice_note, voice_velocity, voice_level, voice_stage, bend_value
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,  // last_voice
  output int                     fail_count,
  output int                     pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   vel;
    logic [LEVEL_W-1:0] level;
    logic [STAGE_W-1:0] stage;
    logic [BEND_W-1:0]  bend;
    logic               last;
  } voice_result_t;

  voice_result_t voice_results_q[$];

  // Local copy of the envelope settings
  logic [LEVEL_W-1:0] attack_rate, decay_rate, sustain_hold, release_rate;

  // Local copy of the voice table and key map
  stage_t             voice_stage[VOICES];
  logic [NOTE_W-1:0]  voice_note[VOICES];
  logic [VEL_W-1:0]   voice_vel[VOICES];
  logic [LEVEL_W-1:0] voice_level[VOICES];
  logic               key_held[KEYS];
  int                 key_voice[KEYS];
  logic [BEND_W-1:0]  bend_reg;

  int mismatches;

  // Release every sounding voice that holds this note
  function automatic void release_key(logic [NOTE_W-1:0] note);
    for (int v = 0; v < VOICES; v++) begin
      if (voice_note[v] == note && voice_stage[v] != ST_IDLE) begin
        voice_stage[v] = ST_RELEASE;
        key_held[note] = 1'b0;
      end
    end
  endfunction

  // Retrigger: release the old owner, then claim the lowest idle voice
  function automatic void start_key(logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
    logic claimed;
    claimed = 1'b0;
    if (key_held[note] && key_voice[note] < VOICES)
      voice_stage[key_voice[note]] = ST_RELEASE;
    key_held[note] = 1'b0;
    for (int v = 0; v < VOICES; v++) begin
      if (!claimed && voice_stage[v] == ST_IDLE) begin
        claimed        = 1'b1;
        voice_stage[v] = ST_ATTACK;
        voice_note[v]  = note;
        voice_vel[v]   = vel;
        voice_level[v] = '0;
        key_held[note] = 1'b1;
        key_voice[note] = v;
      end
    end
  endfunction

  // Advance one voice's envelope by one sample
  function automatic void advance_envelope(int v);
    logic [LEVEL_W:0] sum;
    case (voice_stage[v])
      ST_ATTACK: begin
        sum = {1'b0, voice_level[v]} + {1'b0, attack_rate};
        if (sum[LEVEL_W]) sum = {1'b0, {LEVEL_W{1'b1}}};
        voice_level[v] = sum[LEVEL_W-1:0];
        if (voice_level[v] >= 16'h8000) voice_stage[v] = ST_DECAY;
      end
      ST_DECAY: begin
        voice_level[v] = (voice_level[v] > decay_rate) ? voice_level[v] - decay_rate : '0;
        if (voice_level[v] <= sustain_hold) voice_stage[v] = ST_SUSTAIN;
      end
      ST_SUSTAIN: begin
        voice_level[v] = sustain_hold;
      end
      ST_RELEASE: begin
        voice_level[v] = (voice_level[v] > release_rate) ?
                         voice_level[v] - release_rate : '0;
        if (voice_level[v] == '0) voice_stage[v] = ST_IDLE;
      end
      default: begin
        voice_stage[v] = ST_IDLE;
        voice_level[v] = '0;
      end
    endcase
  endfunction

  // For each voice, queue a result with the level from before its envelope step
  function automatic void predict_tick();
    voice_result_t r;
    for (int v = 0; v < VOICES; v++) begin
      r.level = (voice_stage[v] == ST_IDLE) ? '0 : voice_level[v];
      advance_envelope(v);
      r.index = IDX_W'(v);
      r.note  = voice_note[v];
      r.vel   = voice_vel[v];
      r.stage = voice_stage[v];
      r.bend  = bend_reg;
      r.last  = (v == VOICES - 1);
      voice_results_q.push_back(r);
    end
  endfunction

  function automatic void apply_event(logic [7:0] status, logic [NOTE_W-1:0] d1,
                                      logic [VEL_W-1:0] d2);
    case (status[7:4])
      MSG_NOTE_OFF: release_key(d1);
      MSG_NOTE_ON: begin
        if (d2 == '0) release_key(d1);
        else start_key(d1, d2);
      end
      MSG_BEND: bend_reg = {d2, d1};
      default: ;
    endcase
  endfunction

  function automatic void note_failure(string what, voice_result_t want, voice_result_t got);
    fail_count++;
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t %s: exp idx=%0d note=%0d vel=%0d lvl=%0d stg=%0d bend=%0d last=%0b | got idx=%0d note=%0d vel=%0d lvl=%0d stg=%0d bend=%0d last=%0b",
               $realtime, what, want.index, want.note, want.vel, want.level, want.stage,
               want.bend, want.last, got.index, got.note, got.vel, got.level, got.stage,
               got.bend, got.last);
  endfunction

  initial begin
    fail_count = 0;
    mismatches = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    voice_result_t got, want;
    if (!rst_n) begin
      voice_results_q.delete();
      attack_rate  = ATTACK_RST;
      decay_rate   = DECAY_RST;
      sustain_hold = SUSTAIN_RST;
      release_rate = RELEASE_RST;
      for (int v = 0; v < VOICES; v++) begin
        voice_stage[v] = ST_IDLE;
        voice_note[v]  = '0;
        voice_vel[v]   = '0;
        voice_level[v] = '0;
      end
      for (int k = 0; k < KEYS; k++) begin
        key_held[k]  = 1'b0;
        key_voice[k] = 0;
      end
      bend_reg = BEND_CENTER;
    end else begin
      // Compare a result transaction with the oldest prediction
      if (out_tvalid && out_tready) begin
        got.index = out_tdata[3:0];
        got.note  = out_tdata[10:4];
        got.vel   = out_tdata[17:11];
        got.level = out_tdata[33:18];
        got.stage = out_tdata[36:34];
        got.bend  = out_tdata[50:37];
        got.last  = out_tlast;
        if (voice_results_q.size() == 0) begin
          want = '0;
          note_failure("unexpected result", want, got);
        end else begin
          want = voice_results_q.pop_front();
          if (got.index !== want.index || got.note !== want.note ||
              got.vel !== want.vel || got.level !== want.level ||
              got.stage !== want.stage || got.bend !== want.bend ||
              got.last !== want.last)
            note_failure("result mismatch", want, got);
        end
      end

      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTACK:  attack_rate  = cfg_wdata;
          CFG_DECAY:   decay_rate   = cfg_wdata;
          CFG_SUSTAIN: sustain_hold = cfg_wdata;
          CFG_RELEASE: release_rate = cfg_wdata;
          default: ;
        endcase
      end

      // Predict from an input transaction
      if (in_tvalid && in_tready) begin
        if (in_tuser) predict_tick();
        else apply_event(in_tdata[7:0], in_tdata[14:8], in_tdata[21:15]);
      end
    end
    pending_results <= voice_results_q.size();
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the MIDI voice allocator with ADSR envelopes.
// ----------------------------------------------------------------------------
// A directed burst covers bend extremes, voice exhaustion, retrigger, note-off
// forms and ignored messages. Six random segments follow, each with its own
// envelope settings (extremes, overflow and zero steps among them); the first
// four idle randomly on both sides. One long receiver hold-off fills the block.
module testbench import mvae_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Slowest legal run: ~410 items, each tick 2 results, and one long hold-off;
  // no single quiet stretch comes near this.
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_LIMIT = 12;
  localparam int SEG_ITEMS    = 65;
  localparam int HOLD_CYCLES  = 120;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [LEVEL_W-1:0]     cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  int fail_count;
  int pending_results;
  int send_idle_pct = 16;
  int recv_idle_pct = 61;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  logic [NOTE_W-1:0] note_pool[4];

  midi_voice_allocator_envelope u_top (.*);

  voice_checker u_checker (.*);

  always #2 clk = ~clk;

  // Drive the result-side ready: one long hold-off on request, else random
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stop the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one item after random idle cycles; return at the falling edge
  task automatic send_item(input logic req, input logic [7:0] status,
                           input logic [NOTE_W-1:0] d1, input logic [VEL_W-1:0] d2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= IN_TDATA_W'({d2, d1, status});
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom_range(255)), 7'($urandom_range(127)),
              7'($urandom_range(127)));
  endtask

  // Drop valid, wait for every result, then let queued events retire
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_LIMIT) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_envelope(input logic [LEVEL_W-1:0] a, input logic [LEVEL_W-1:0] d,
                               input logic [LEVEL_W-1:0] s, input logic [LEVEL_W-1:0] r);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ATTACK;
    cfg_wdata <= a;
    @(negedge clk);
    cfg_index <= CFG_DECAY;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_index <= CFG_SUSTAIN;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_index <= CFG_RELEASE;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly keys from a small pool so that note-offs find their voice
  function automatic logic [NOTE_W-1:0] pick_note();
    if ($urandom_range(99) < 75) return note_pool[$urandom_range(3)];
    return NOTE_W'($urandom_range(127));
  endfunction

  task automatic send_random_item();
    int pick;
    logic [3:0] chan;
    logic [VEL_W-1:0] vel;
    pick = $urandom_range(99);
    chan = 4'($urandom_range(15));
    if (pick < 45) begin
      send_tick();
    end else if (pick < 70) begin
      vel = ($urandom_range(9) == 0) ? '0 : VEL_W'($urandom_range(127, 1));
      send_item(1'b0, {MSG_NOTE_ON, chan}, pick_note(), vel);
    end else if (pick < 85) begin
      send_item(1'b0, {MSG_NOTE_OFF, chan}, pick_note(), VEL_W'($urandom_range(127)));
    end else if (pick < 90) begin
      send_item(1'b0, {MSG_BEND, chan}, NOTE_W'($urandom_range(127)),
                VEL_W'($urandom_range(127)));
    end else begin
      send_item(1'b0, 8'($urandom_range(255)), NOTE_W'($urandom_range(127)),
                VEL_W'($urandom_range(127)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed burst with reset envelope settings
    send_item(1'b1, 8'h00, 7'd0, 7'd0);
    send_item(1'b0, {MSG_BEND, 4'h0}, 7'd0, 7'd0);
    send_item(1'b1, 8'h00, 7'd0, 7'd0);
    send_item(1'b0, {MSG_NOTE_ON, 4'h0}, 7'd0, 7'd127);
    send_item(1'b0, {MSG_NOTE_ON, 4'hF}, 7'd127, 7'd1);
    // No idle voice left: dropped
    send_item(1'b0, {MSG_NOTE_ON, 4'h3}, 7'd60, 7'd50);
    send_item(1'b1, 8'hFF, 7'd127, 7'd127);
    // Retrigger a held key while all voices are busy
    send_item(1'b0, {MSG_NOTE_ON, 4'h0}, 7'd127, 7'd64);
    send_item(1'b1, 8'h00, 7'd0, 7'd0);
    send_item(1'b0, {MSG_NOTE_OFF, 4'hA}, 7'd0, 7'd127);
    send_item(1'b1, 8'h00, 7'd0, 7'd0);
    // Note-on with zero velocity acts as note-off
    send_item(1'b0, {MSG_NOTE_ON, 4'h5}, 7'd42, 7'd0);
    send_item(1'b0, {MSG_BEND, 4'hF}, 7'd127, 7'd127);
    // Ignored messages, system messages included
    send_item(1'b0, {MSG_SYSTEM, 4'h0}, 7'd1, 7'd1);
    send_item(1'b0, 8'hFF, 7'd127, 7'd127);
    send_item(1'b0, 8'hA0, 7'd0, 7'd100);
    send_item(1'b0, 8'hB7, 7'd5, 7'd5);
    send_item(1'b0, 8'hC3, 7'd2, 7'd0);
    send_item(1'b0, 8'hD9, 7'd9, 7'd9);
    send_item(1'b0, 8'h7F, 7'd64, 7'd64);
    send_item(1'b1, 8'h00, 7'd0, 7'd0);
    send_item(1'b1, 8'h00, 7'd0, 7'd0);

    // Random segments, each with its own settings and idling pattern
    for (int seg = 0; seg < 6; seg++) begin
      settle();
      case (seg)
        0: load_envelope(16'd32768, 16'd32768, 16'd0, 16'd32768);
        2: load_envelope(16'hFFFF, 16'd0, 16'd32768, 16'd0);
        4: load_envelope(16'd0, 16'd100, 16'd16384, 16'd32768);
        default: load_envelope(LEVEL_W'($urandom_range(8000, 300)),
                               LEVEL_W'($urandom_range(8000, 300)),
                               LEVEL_W'($urandom_range(32768)),
                               LEVEL_W'($urandom_range(8000, 300)));
      endcase
      if (seg < 2) begin
        send_idle_pct <= 16;
        recv_idle_pct <= 61;
      end else if (seg < 4) begin
        send_idle_pct <= 61;
        recv_idle_pct <= 16;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      for (int k = 0; k < 4; k++) note_pool[k] = NOTE_W'($urandom_range(127));
      @(negedge clk);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // Hold off the receiver while ticks keep coming
        if (seg == 5 && n == 8) hold_req <= 1'b1;
        if (seg == 5 && n >= 8 && n < 20) send_tick();
        else send_random_item();
      end
    end

    settle();
    if (fail_count == 0 && pending_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
